// File: design/trs_pkg.sv
// Shared types, constants and compare function for the threshold record sorter.
`timescale 1ns / 1ps

package trs_pkg;

  localparam int MaxRecords = 64;
  localparam int CountW     = $clog2(MaxRecords + 1);
  localparam int MarkW      = 16;
  localparam int NameW      = 64;

  typedef logic [MarkW-1:0]  mark_t;
  typedef logic [NameW-1:0]  name_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StDrain = 2'b10
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic pop;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic one_left;
  } status_t;

  // record a sorts strictly after record b
  function automatic logic sorts_after(mark_t ma, name_t na, mark_t mb, name_t nb);
    logic res;
    if (ma != mb) begin
      res = (ma > mb);
    end else begin
      res = (na > nb);
    end
    return res;
  endfunction

endpackage

// File: design/trs_ctrl.sv
// Controller: load and drain sequencing for the threshold record sorter.
`timescale 1ns / 1ps

module trs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_in_i,
  input  trs_pkg::status_t status_i,
  output trs_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  trs_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == trs_pkg::StIdle);
  assign busy_o = (state_q == trs_pkg::StDrain);

  always_comb begin
    state_d      = state_q;
    cmd_o.insert = 1'b0;
    cmd_o.pop    = 1'b0;
    unique case (state_q)
      trs_pkg::StIdle: begin
        if (accept) begin
          cmd_o.insert = 1'b1;
          if (last_in_i) begin
            state_d = trs_pkg::StDrain;
          end
        end
      end
      trs_pkg::StDrain: begin
        cmd_o.pop = 1'b1;
        if (status_i.one_left) begin
          state_d = trs_pkg::StIdle;
        end
      end
      default: begin
        state_d = trs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/trs_datapath.sv
// Datapath: sorted insertion chain, record count, overflow flag and result registers.
`timescale 1ns / 1ps

module trs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trs_pkg::cmd_t     cmd_i,
  output trs_pkg::status_t  status_o,
  input  logic              cfg_we_i,
  input  trs_pkg::mark_t    cfg_wdata_i,
  input  trs_pkg::mark_t    mark_in_i,
  input  trs_pkg::name_t    name_key_in_i,
  output logic              result_valid_o,
  output trs_pkg::name_t    name_key_out_o,
  output trs_pkg::mark_t    mark_out_o,
  output logic              empty_out_o,
  output logic              overflow_out_o,
  output logic              last_out_o
);

  trs_pkg::mark_t  mark_q [trs_pkg::MaxRecords];
  trs_pkg::name_t  name_q [trs_pkg::MaxRecords];
  trs_pkg::count_t count_q;
  logic            ovf_q;
  trs_pkg::mark_t  min_mark_q;

  logic                           full;
  logic [trs_pkg::MaxRecords-1:0] gt;
  logic                           pass;
  logic                           one_left;

  logic            valid_q;
  trs_pkg::name_t  name_out_q;
  trs_pkg::mark_t  mark_out_q;
  logic            empty_q;
  logic            ovf_out_q;
  logic            last_q;

  assign full     = (count_q == trs_pkg::count_t'(trs_pkg::MaxRecords));
  assign one_left = (count_q == trs_pkg::count_t'(1));
  assign pass     = (mark_q[0] >= min_mark_q);
  assign status_o.one_left = one_left;

  // cells past the fill level count as sorting after anything
  always_comb begin
    for (int i = 0; i < trs_pkg::MaxRecords; i++) begin
      gt[i] = (trs_pkg::count_t'(i) >= count_q) ||
              trs_pkg::sorts_after(mark_q[i], name_q[i], mark_in_i, name_key_in_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < trs_pkg::MaxRecords; i++) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            mark_q[i] <= mark_q[(i > 0) ? i - 1 : 0];
            name_q[i] <= name_q[(i > 0) ? i - 1 : 0];
          end else begin
            mark_q[i] <= mark_in_i;
            name_q[i] <= name_key_in_i;
          end
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < trs_pkg::MaxRecords - 1; i++) begin
        mark_q[i] <= mark_q[i+1];
        name_q[i] <= name_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      min_mark_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_mark_q <= cfg_wdata_i;
      end
      if (cmd_i.insert) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + trs_pkg::count_t'(1);
        end
      end else if (cmd_i.pop) begin
        count_q <= count_q - trs_pkg::count_t'(1);
        if (one_left) begin
          ovf_q <= 1'b0;
        end
      end
      valid_q <= cmd_i.pop && (pass || one_left);
    end
  end

  // the largest record drains last, so the final pop decides last/empty
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      name_out_q <= pass ? name_q[0] : '0;
      mark_out_q <= pass ? mark_q[0] : '0;
      empty_q    <= !pass;
      ovf_out_q  <= ovf_q;
      last_q     <= one_left;
    end
  end

  assign result_valid_o = valid_q;
  assign name_key_out_o = name_out_q;
  assign mark_out_o     = mark_out_q;
  assign empty_out_o    = empty_q;
  assign overflow_out_o = ovf_out_q;
  assign last_out_o     = last_q;

endmodule

// File: design/threshold_record_sorter.sv
// Top level of the threshold record sorter: controller plus datapath.
//
// Records are taken one per cycle while busy_o is low; each is inserted in
// sorted place (mark, then name key, ascending) by a row of 64 compare cells.
// The item with last_in_i high starts the drain: busy_o stays high until every
// held record has been popped (one pop of the cell row per cycle), and every
// record whose mark is at least the threshold comes out on a one-cycle
// result_valid_o strobe, in the cycle after its pop. The receiver cannot stall,
// so results must be captured on the strobe. If nothing passes, one result
// with empty_out_o set is given. Records beyond 64 are dropped and flagged on
// every result of that set. Write the threshold only while busy_o is low and
// no result is pending.
`timescale 1ns / 1ps

module threshold_record_sorter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [15:0]         mark_in_i,
  input  logic [63:0]         name_key_in_i,
  input  logic                last_in_i,
  output logic                result_valid_o,
  output logic [63:0]         name_key_out_o,
  output logic [15:0]         mark_out_o,
  output logic                empty_out_o,
  output logic                overflow_out_o,
  output logic                last_out_o
);

  trs_pkg::cmd_t    cmd;
  trs_pkg::status_t status;

  trs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .last_in_i (last_in_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  trs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mark_in_i      (mark_in_i),
    .name_key_in_i  (name_key_in_i),
    .result_valid_o (result_valid_o),
    .name_key_out_o (name_key_out_o),
    .mark_out_o     (mark_out_o),
    .empty_out_o    (empty_out_o),
    .overflow_out_o (overflow_out_o),
    .last_out_o     (last_out_o)
  );

endmodule
